// ===== src/dfs_adjacency_matrix_walk_macros.svh =====
// Assertion macros for the depth-first walk block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef DFS_ADJACENCY_MATRIX_WALK_MACROS_SVH
`define DFS_ADJACENCY_MATRIX_WALK_MACROS_SVH

// same-cycle implication
`define DFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dfs_pkg.sv =====
// Shared types, constants, microcode table and helpers of the depth-first walk.
// No dependencies.
package dfs_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int NODE_LIMIT    = 16;   // node fields are 4 bits wide
  localparam int NODE_W        = 4;
  localparam int ROW_W         = 16;
  localparam int CNT_W         = 5;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;
  localparam logic REG_NODE_COUNT = 1'b0;

  // input transaction modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_WALK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_POP,
    ST_FIN
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START_REQ,
    C_START_BAD,
    C_CAND,
    C_EMPTY
  } cond_t;

  typedef struct packed {
    logic  take_in;   // input channel open
    logic  init;      // seed walk from latched start node
    logic  scan;      // pick successor or pop
    logic  pop;       // re-read row of new stack top
    logic  fin;       // flush pending node with last set
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   hold;     // output register full, step frozen
  } ctl_t;

  typedef struct packed {
    logic start_req;
    logic start_bad;
    logic cand;
    logic empty;
    logic out_busy;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      ST_IDLE: begin
        w.take_in = 1'b1; w.cond = C_START_REQ; w.tgt_t = ST_START; w.tgt_f = ST_IDLE;
      end
      ST_START: begin
        w.init = 1'b1; w.cond = C_START_BAD; w.tgt_t = ST_IDLE; w.tgt_f = ST_SCAN;
      end
      ST_SCAN: begin
        w.scan = 1'b1; w.cond = C_CAND; w.tgt_t = ST_SCAN; w.tgt_f = ST_POP;
      end
      ST_POP: begin
        w.pop = 1'b1; w.cond = C_EMPTY; w.tgt_t = ST_FIN; w.tgt_f = ST_SCAN;
      end
      ST_FIN: begin
        w.fin = 1'b1; w.cond = C_ALWAYS; w.tgt_t = ST_IDLE; w.tgt_f = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.tgt_t = ST_IDLE; w.tgt_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // priority encoder, lowest set bit wins
  function automatic logic [NODE_W-1:0] lowest_bit(input logic [ROW_W-1:0] m);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (m[i]) r = NODE_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/dfs_adjacency_matrix_walk.sv =====
// Top level of the depth-first walk: config register, sequencer and datapath.
// Depends on dfs_pkg, dfs_useq, dfs_dpath.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+------------------------
//   in      | mode, row_index, row_edges, start   | in_valid / in_stall
//   out     | visited_node, last                  | out_valid / out_stall
//   cfg     | psel penable pwrite paddr pwdata    | APB, pready tied high
//
// A row load leaves the sequencer in ST_IDLE, so loads can follow back to back. A
// forward step reads the next row from the row RAM; a backtrack reads the stack RAM
// and then the row RAM of the new top; node-emitting steps wait on a stalled output.
// Synchronous active-low reset; the row store holds no valid bits and needs no sweep.
// A new transaction is taken while the last result still waits in the output register.
module dfs_adjacency_matrix_walk #(
  parameter int MAX_NODES = dfs_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [dfs_pkg::NODE_W-1:0]   in_row_index,
  input  logic [dfs_pkg::ROW_W-1:0]    in_row_edges,
  input  logic [dfs_pkg::NODE_W-1:0]   in_start_node,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dfs_pkg::NODE_W-1:0]   out_visited_node,
  output logic                         out_last,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dfs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dfs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dfs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int SDEPTH = (MAX_NODES < dfs_pkg::NODE_LIMIT) ? MAX_NODES : dfs_pkg::NODE_LIMIT;
  localparam int CW     = dfs_pkg::CNT_W;

  logic [CW-1:0]  node_count_r, n_eff;
  logic           reg_sel;
  dfs_pkg::ctl_t  ctl;
  dfs_pkg::stat_t stat;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[dfs_pkg::CFG_AW-1:2] == dfs_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= dfs_pkg::NODE_COUNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      node_count_r <= cfg_pwdata[CW-1:0];
    end
  end

  assign cfg_prdata = reg_sel ? dfs_pkg::CFG_DW'(node_count_r) : '0;

  always_comb begin
    priority if (node_count_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(node_count_r) > SDEPTH) begin
      n_eff = CW'(SDEPTH);
    end else begin
      n_eff = node_count_r;
    end
  end

  dfs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  dfs_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .n_eff            (n_eff),
    .in_valid         (in_valid),
    .in_mode          (in_mode),
    .in_row_index     (in_row_index),
    .in_row_edges     (in_row_edges),
    .in_start_node    (in_start_node),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_visited_node (out_visited_node),
    .out_last         (out_last)
  );

  assign in_stall = ~ctl.uc.take_in;

endmodule

// ===== src/dfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/dfs_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on dfs_pkg.
module dfs_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  dfs_pkg::stat_t stat,
  output dfs_pkg::ctl_t  ctl
);

  dfs_pkg::step_t  step_r, step_nxt;
  dfs_pkg::ucode_t uc;
  logic            hold;
  logic            cond_ok;

  assign uc = dfs_pkg::ucode_rom(step_r);
  // only steps that emit a node can be frozen by a full output register
  assign hold = ((uc.scan && stat.cand) || uc.fin) && stat.out_busy;

  always_comb begin
    unique case (uc.cond)
      dfs_pkg::C_ALWAYS:    cond_ok = 1'b1;
      dfs_pkg::C_START_REQ: cond_ok = stat.start_req;
      dfs_pkg::C_START_BAD: cond_ok = stat.start_bad;
      dfs_pkg::C_CAND:      cond_ok = stat.cand;
      dfs_pkg::C_EMPTY:     cond_ok = stat.empty;
      default:              cond_ok = 1'b1;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = cond_ok ? uc.tgt_t : uc.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dfs_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.uc   = uc;
  assign ctl.hold = hold;

endmodule

// ===== src/dfs_dpath.sv =====
// Walk datapath: row and stack RAMs, visited mask, stack pointer, output register.
// Depends on dfs_pkg and dfs_ram.
module dfs_dpath #(
  parameter int MAX_NODES = dfs_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dfs_pkg::ctl_t               ctl,
  output dfs_pkg::stat_t              stat,
  input  logic [dfs_pkg::CNT_W-1:0]   n_eff,
  input  logic                        in_valid,
  input  logic                        in_mode,
  input  logic [dfs_pkg::NODE_W-1:0]  in_row_index,
  input  logic [dfs_pkg::ROW_W-1:0]   in_row_edges,
  input  logic [dfs_pkg::NODE_W-1:0]  in_start_node,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dfs_pkg::NODE_W-1:0]  out_visited_node,
  output logic                        out_last
);

  localparam int SDEPTH = (MAX_NODES < dfs_pkg::NODE_LIMIT) ? MAX_NODES : dfs_pkg::NODE_LIMIT;
  localparam int AW     = $clog2(SDEPTH);
  localparam int SPW    = $clog2(SDEPTH + 1);
  localparam int NW     = dfs_pkg::NODE_W;
  localparam int RW     = dfs_pkg::ROW_W;

  logic [NW-1:0]  start_r, pend_r, out_node_r;
  logic [RW-1:0]  visited_r;
  logic [SPW-1:0] sp_r, sp_m2;
  logic           out_valid_r, out_last_r;

  logic           go, take, push, retreat, emit, start_bad;
  logic [RW-1:0]  in_use, cand, adj_rdata;
  logic           cand_any;
  logic [NW-1:0]  nxt_node, stk_rdata, stk_wdata, adj_raddr_n;
  logic           adj_we, adj_re, stk_we, stk_re;
  logic [AW-1:0]  stk_waddr;

  assign in_use   = RW'((17'd1 << n_eff) - 17'd1);
  assign cand     = adj_rdata & in_use & ~visited_r;
  assign cand_any = |cand;
  assign nxt_node = dfs_pkg::lowest_bit(cand);

  assign go        = ~ctl.hold;
  assign take      = ctl.uc.take_in && in_valid;
  assign start_bad = {1'b0, start_r} >= n_eff;
  assign push      = ctl.uc.scan && cand_any && go;
  assign retreat   = ctl.uc.scan && !cand_any;
  assign emit      = (push || ctl.uc.fin) && go;
  assign sp_m2     = sp_r - SPW'(2);

  assign adj_we = take && (in_mode == dfs_pkg::MODE_LOAD) && (int'(in_row_index) < MAX_NODES);

  always_comb begin
    priority if (ctl.uc.init) begin
      adj_re      = 1'b1;
      adj_raddr_n = start_r;
    end else if (push) begin
      adj_re      = 1'b1;
      adj_raddr_n = nxt_node;
    end else if (ctl.uc.pop && sp_r != '0) begin
      adj_re      = 1'b1;
      adj_raddr_n = stk_rdata;
    end else begin
      adj_re      = 1'b0;
      adj_raddr_n = start_r;
    end
  end

  assign stk_we    = (ctl.uc.init && !start_bad) || push;
  assign stk_waddr = ctl.uc.init ? AW'(0) : sp_r[AW-1:0];
  assign stk_wdata = ctl.uc.init ? start_r : nxt_node;
  // after a pop the new top sits two below the current pointer
  assign stk_re    = retreat;

  dfs_ram #(.WIDTH(RW), .DEPTH(SDEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (in_row_index[AW-1:0]),
    .wdata (in_row_edges),
    .re    (adj_re),
    .raddr (adj_raddr_n[AW-1:0]),
    .rdata (adj_rdata)
  );

  dfs_ram #(.WIDTH(NW), .DEPTH(SDEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (sp_m2[AW-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.uc.init) begin
        sp_r      <= start_bad ? SPW'(0) : SPW'(1);
        visited_r <= start_bad ? RW'(0) : (RW'(1) << start_r);
      end else if (push) begin
        sp_r      <= sp_r + SPW'(1);
        visited_r <= visited_r | (RW'(1) << nxt_node);
      end else if (retreat) begin
        sp_r <= sp_r - SPW'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pend_r holds the newest node until we know whether it is the last one
  always_ff @(posedge clk) begin
    if (take) start_r <= in_start_node;
    if (ctl.uc.init) begin
      pend_r <= start_r;
    end else if (push) begin
      pend_r <= nxt_node;
    end
    if (emit) begin
      out_node_r <= pend_r;
      out_last_r <= ctl.uc.fin;
    end
  end

  assign stat.start_req = take && (in_mode == dfs_pkg::MODE_WALK);
  assign stat.start_bad = start_bad;
  assign stat.cand      = cand_any;
  assign stat.empty     = (sp_r == '0);
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;

endmodule

// ===== src/dfs_walk_chk.sv =====
// Port-level checker for the depth-first walk, bound to the top level.
// Depends on dfs_pkg and dfs_adjacency_matrix_walk_macros.svh.
`include "dfs_adjacency_matrix_walk_macros.svh"

module dfs_walk_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_mode,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dfs_pkg::NODE_W-1:0]   out_visited_node,
  input logic                         out_last
);

  // stalled result holds
  `DFS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_visited_node) && $stable(out_last), "stalled result changed")

  // a start transaction closes the input channel on the next cycle
  `DFS_ASSERT_NXT(a_start_busy, in_valid && !in_stall && (in_mode == dfs_pkg::MODE_WALK), in_stall, "input taken right after a start")

  // while a walk still owes its last node, no input is taken
  `DFS_ASSERT_IMP(a_walk_busy, out_valid && !out_last, in_stall, "input open during a walk")

endmodule

bind dfs_adjacency_matrix_walk dfs_walk_chk u_dfs_walk_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_visited_node (out_visited_node),
  .out_last         (out_last)
);

// ===== test/dfs_adjacency_matrix_walk_tb.sv =====
// Self-checking testbench for dfs_adjacency_matrix_walk: loads adjacency rows, runs
// depth-first walks, and checks each preorder node against a built-in predictor.
// Depends on dfs_pkg and the dfs_adjacency_matrix_walk RTL.
`timescale 1ns / 1ps

module dfs_adjacency_matrix_walk_tb;

  localparam int REG_UNMAPPED = 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 63;

  typedef struct packed {
    logic                       mode;
    logic [dfs_pkg::NODE_W-1:0] row;
    logic [dfs_pkg::ROW_W-1:0]  edges;
    logic [dfs_pkg::NODE_W-1:0] origin;
  } graph_op_t;

  typedef struct packed {
    logic [dfs_pkg::NODE_W-1:0] node;
    logic                       last;
  } visit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = dfs_pkg::MODE_LOAD;
  logic [dfs_pkg::NODE_W-1:0] in_row_index = '0;
  logic [dfs_pkg::ROW_W-1:0] in_row_edges = '0;
  logic [dfs_pkg::NODE_W-1:0] in_start_node = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dfs_pkg::NODE_W-1:0] out_visited_node;
  logic out_last;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [dfs_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [dfs_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [dfs_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  graph_op_t ops_pending [$];
  visit_t visits_due [$];
  graph_op_t cur_op;
  visit_t head_visit;

  // predictor state
  logic [dfs_pkg::ROW_W-1:0] node_rows [dfs_pkg::NODE_LIMIT];
  logic [dfs_pkg::CNT_W-1:0] node_count_q = dfs_pkg::NODE_COUNT_RST;

  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  logic hold_started = 1'b0;
  int hold_left = 0;
  int bad_count = 0;
  int cycle_count = 0;

  dfs_adjacency_matrix_walk DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    bad_count++;
  endtask

  function automatic int active_count();
    if (node_count_q == 0) return 1;
    if (node_count_q > dfs_pkg::NODE_LIMIT) return dfs_pkg::NODE_LIMIT;
    return node_count_q;
  endfunction

  // expected preorder of one walk, last flag on the final node
  function automatic void predict_walk(input logic [dfs_pkg::NODE_W-1:0] origin);
    int n, depth, count, j, i;
    logic [dfs_pkg::ROW_W-1:0] in_use, seen, cand;
    logic [dfs_pkg::NODE_W-1:0] stack [dfs_pkg::NODE_LIMIT];
    logic [dfs_pkg::NODE_W-1:0] order [dfs_pkg::NODE_LIMIT];
    visit_t v;
    n = active_count();
    in_use = {dfs_pkg::ROW_W{1'b1}} >> (dfs_pkg::ROW_W - n);
    if (origin >= n) return;
    seen = '0;
    seen[origin] = 1'b1;
    stack[0] = origin;
    order[0] = origin;
    depth = 1;
    count = 1;
    while (depth > 0) begin
      cand = node_rows[stack[depth-1]] & in_use & ~seen;
      if (cand != '0 && count < dfs_pkg::NODE_LIMIT && depth < dfs_pkg::MAX_NODES_DEF) begin
        j = 0;
        while (!cand[j]) j++;
        seen[j] = 1'b1;
        stack[depth] = dfs_pkg::NODE_W'(j);
        order[count] = dfs_pkg::NODE_W'(j);
        depth++;
        count++;
      end else begin
        depth--;
      end
    end
    for (i = 0; i < count; i++) begin
      v.node = order[i];
      v.last = (i == count - 1);
      visits_due = {visits_due, v};
    end
  endfunction

  // monitor: timeout, result check, prediction on accepted transactions
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      flag_mismatch($sformatf("timeout after %0d cycles, %0d nodes outstanding",
                              cycle_count, visits_due.size()));
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (visits_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected node %0d last %0b", out_visited_node, out_last));
        end else begin
          head_visit = visits_due.pop_front();
          if (out_visited_node !== head_visit.node)
            flag_mismatch($sformatf("visited_node %0d, want %0d", out_visited_node,
                                    head_visit.node));
          if (out_last !== head_visit.last)
            flag_mismatch($sformatf("last %0b on node %0d, want %0b", out_last,
                                    head_visit.node, head_visit.last));
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (in_mode == dfs_pkg::MODE_LOAD) node_rows[in_row_index] = in_row_edges;
        else predict_walk(in_start_node);
      end
    end
  end

  // driver: payload holds while stalled
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (ops_pending.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
        cur_op = ops_pending.pop_front();
        in_valid <= 1'b1;
        in_mode <= cur_op.mode;
        in_row_index <= cur_op.row;
        in_row_edges <= cur_op.edges;
        in_start_node <= cur_op.origin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  task automatic write_reg(input int idx, input logic [dfs_pkg::CFG_DW-1:0] value);
    logic [dfs_pkg::CFG_DW-1:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= dfs_pkg::CFG_AW'(idx * 4);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == dfs_pkg::REG_NODE_COUNT) node_count_q = value[dfs_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == dfs_pkg::REG_NODE_COUNT &&
        readback[dfs_pkg::CNT_W-1:0] !== node_count_q)
      flag_mismatch($sformatf("node_count reads %0d, want %0d",
                              readback[dfs_pkg::CNT_W-1:0], node_count_q));
  endtask

  task automatic queue_load(input logic [dfs_pkg::NODE_W-1:0] row,
                            input logic [dfs_pkg::ROW_W-1:0] edges);
    graph_op_t op;
    op.mode = dfs_pkg::MODE_LOAD;
    op.row = row;
    op.edges = edges;
    op.origin = dfs_pkg::NODE_W'($urandom);
    ops_pending = {ops_pending, op};
  endtask

  task automatic queue_walk(input logic [dfs_pkg::NODE_W-1:0] origin);
    graph_op_t op;
    op.mode = dfs_pkg::MODE_WALK;
    op.row = dfs_pkg::NODE_W'($urandom);
    op.edges = dfs_pkg::ROW_W'($urandom);
    op.origin = origin;
    ops_pending = {ops_pending, op};
  endtask

  function automatic logic [dfs_pkg::ROW_W-1:0] rand_edges();
    case ($urandom_range(4))
      0: return dfs_pkg::ROW_W'($urandom & $urandom & $urandom);
      1: return dfs_pkg::ROW_W'(1) << $urandom_range(dfs_pkg::ROW_W - 1);
      2: return dfs_pkg::ROW_W'($urandom | $urandom);
      3: return dfs_pkg::ROW_W'($urandom);
      default: return dfs_pkg::ROW_W'($urandom & $urandom);
    endcase
  endfunction

  // wait until every transaction is in and every node is out, then let the walk settle
  task automatic drain();
    @(posedge clk);
    while (ops_pending.size() != 0 || in_valid || visits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int p, k, walk_pct;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // chain with back edges to node 0; row 0 reaches all, row 15 is a sink
    queue_load(4'd0, 16'hFFFF);
    for (k = 1; k < 15; k++)
      queue_load(dfs_pkg::NODE_W'(k), (dfs_pkg::ROW_W'(1) << (k + 1)) | 16'h0001);
    queue_load(4'd15, 16'h0000);
    queue_walk(4'd0);
    queue_walk(4'd15);
    queue_walk(4'd7);
    queue_load(4'd5, 16'h0000);
    queue_walk(4'd3);
    queue_load(4'd5, 16'h8000);
    queue_walk(4'd3);
    drain();

    write_reg(dfs_pkg::REG_NODE_COUNT, 32'd1);
    @(posedge clk);
    queue_walk(4'd0);
    queue_walk(4'd1);
    drain();

    // zero is taken as one node
    write_reg(dfs_pkg::REG_NODE_COUNT, 32'd0);
    @(posedge clk);
    queue_walk(4'd0);
    queue_walk(4'd2);
    drain();

    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    @(posedge clk);
    queue_walk(4'd0);
    drain();

    // above the node limit saturates
    write_reg(dfs_pkg::REG_NODE_COUNT, 32'hFFFF_FFFF);
    @(posedge clk);
    queue_walk(4'd0);
    drain();

    // edges past the node count are ignored, starts past it yield nothing
    write_reg(dfs_pkg::REG_NODE_COUNT, 32'd5);
    @(posedge clk);
    queue_walk(4'd0);
    queue_walk(4'd5);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: write_reg(dfs_pkg::REG_NODE_COUNT, 32'd16);
        1: write_reg(dfs_pkg::REG_NODE_COUNT, 32'd16);
        2: write_reg(dfs_pkg::REG_NODE_COUNT, 32'd9);
        3: write_reg(dfs_pkg::REG_NODE_COUNT, 32'd3);
        4: write_reg(dfs_pkg::REG_NODE_COUNT, 32'd31);
        default: write_reg(dfs_pkg::REG_NODE_COUNT, dfs_pkg::CFG_DW'($urandom_range(0, 31)));
      endcase
      @(posedge clk);
      quiet = (p == 0);
      if (p == 1) hold_go = 1'b1;
      walk_pct = (p == 1) ? 85 : 45;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < walk_pct) begin
          if ($urandom_range(99) < 88)
            queue_walk(dfs_pkg::NODE_W'($urandom_range(0, active_count() - 1)));
          else
            queue_walk(dfs_pkg::NODE_W'($urandom));
        end else begin
          queue_load(dfs_pkg::NODE_W'($urandom), rand_edges());
        end
      end
      drain();
    end

    if (bad_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
